// ----- rtl/tcw_pkg.sv -----
// shared types and constants for the text console writer
`default_nettype none

package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int          PADDR_W  = 3;
    localparam logic        REG_ATTR = 1'b0;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } tcw_cmd_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_row_out;
        logic [6:0] cursor_col_out;
        logic       scrolled;
    } tcw_rsp_t;

    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [15:0] wdata;
    } tcw_mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/text_console_writer_core.sv -----
// text console writer top level: register port, sequencer and cell memory
//
//  channel | direction | handshake             | payload
//  cmd     | in        | cmd_valid / cmd_ready | tcw_cmd_t
//  rsp     | out       | rsp_valid / rsp_ready | tcw_rsp_t
//  apb     | in        | psel, penable, pready | attribute register at 0
//
// put, newline, read and ignored opcodes: idle, then the finish state; a put on a full
//   row that does not scroll adds a write state that writes the character to the new row
// clear: one cell written per cycle, then the finish state
// scroll: copy rows up, drain, fill the bottom row, then a write state when a put follows it;
//   the copy streams through the memory's one read and one write port
// one item in flight; a finished result waits in the output register while the
//   next item is taken, and the sequencer stalls only if that register is full
// reset clears cursor, attribute and control; cell contents stay undefined
`default_nettype none

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output      logic [31:0]        prdata,
    output      logic               pready,
    input  wire logic               cmd_valid,
    output      logic               cmd_ready,
    input  wire tcw_cmd_t           cmd,
    output      logic               rsp_valid,
    input  wire logic               rsp_ready,
    output      tcw_rsp_t           rsp
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]        attr_reg, attr_next;
    tcw_mem_ctl_t      mem_ctl;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_rd_data;

    assign pready = 1'b1;

    always_comb
    begin
        attr_next = attr_reg;
        if (psel && penable && pwrite && paddr[2] == REG_ATTR)
        begin
            attr_next = pwdata[7:0];
        end
        prdata = (paddr[2] == REG_ATTR) ? {24'd0, attr_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
        end
    end

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .attr        (attr_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mem_ctl     (mem_ctl),
        .mem_waddr   (mem_waddr),
        .mem_raddr   (mem_raddr),
        .mem_rd_data (mem_rd_data)
    );

    tcw_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .waddr   (mem_waddr),
        .raddr   (mem_raddr),
        .rd_data (mem_rd_data)
    );

    // one item at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item accepted while another is in work");

    // a scroll always leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |-> rsp.cursor_row_out == 5'(ROWS - 1))
        else $error("scroll reported off the bottom row");

    // a new result only appears after the sequencer has left idle
    a_rsp_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!cmd_ready))
        else $error("result without work");

endmodule

`default_nettype wire

// ----- rtl/tcw_mem.sv -----
// screen cell memory, one write port and one registered read port
`default_nettype none

module tcw_mem
    import tcw_pkg::*;
#(
    parameter int DEPTH  = DEF_ROWS * DEF_COLUMNS,
    parameter int ADDR_W = $clog2(DEF_ROWS * DEF_COLUMNS)
)
(
    input  wire logic                clk,
    input  wire tcw_mem_ctl_t        ctl,
    input  wire logic [ADDR_W-1:0]   waddr,
    input  wire logic [ADDR_W-1:0]   raddr,
    output      logic [15:0]         rd_data
);

    logic [15:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= ctl.wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_ctrl.sv -----
// sequencer: cursor, put, scroll and clear sweeps, read, result register
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    parameter int ADDR_W  = $clog2(DEF_ROWS * DEF_COLUMNS)
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          attr,
    input  wire logic                cmd_valid,
    output      logic                cmd_ready,
    input  wire tcw_cmd_t            cmd,
    output      logic                rsp_valid,
    input  wire logic                rsp_ready,
    output      tcw_rsp_t            rsp,
    output      tcw_mem_ctl_t        mem_ctl,
    output      logic [ADDR_W-1:0]   mem_waddr,
    output      logic [ADDR_W-1:0]   mem_raddr,
    input  wire logic [15:0]         mem_rd_data
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS + 1);

    localparam logic [ADDR_W-1:0] COL_OFS   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'((ROWS - 1) * COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((ROWS - 1) * COLUMNS);
    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(ROWS * COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_FULL  = COL_W'(COLUMNS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUTW   = 3'd1;
    localparam logic [2:0] S_COPY   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_CLEAR  = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]        state_reg,    state_next;
    logic [ROW_W-1:0]  row_reg,      row_next;
    logic [COL_W-1:0]  col_reg,      col_next;
    logic [ADDR_W-1:0] cnt_reg,      cnt_next;
    logic              wr_pend_reg,  wr_pend_next;
    logic [ADDR_W-1:0] wr_addr_reg,  wr_addr_next;
    logic              put_pend_reg, put_pend_next;
    logic [7:0]        ch_reg,       ch_next;
    logic              rd_flag_reg,  rd_flag_next;
    logic              scroll_reg,   scroll_next;
    logic              rsp_vld_reg,  rsp_vld_next;
    tcw_rsp_t          rsp_reg,      rsp_next;

    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_in_range;

    assign cur_addr    = ADDR_W'(row_reg) * COL_OFS + ADDR_W'(col_reg);
    assign rd_addr     = ADDR_W'(cmd.read_row) * COL_OFS + ADDR_W'(cmd.read_col);
    assign rd_in_range = (32'(cmd.read_row) < 32'(ROWS)) && (32'(cmd.read_col) < 32'(COLUMNS));

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        cnt_next      = cnt_reg;
        wr_pend_next  = wr_pend_reg;
        wr_addr_next  = wr_addr_reg;
        put_pend_next = put_pend_reg;
        ch_next       = ch_reg;
        rd_flag_next  = rd_flag_reg;
        scroll_next   = scroll_reg;
        rsp_vld_next  = rsp_vld_reg;
        rsp_next      = rsp_reg;

        mem_ctl       = '0;
        mem_ctl.wdata = {attr, SPACE_CODE};
        mem_waddr     = cur_addr;
        mem_raddr     = cnt_reg + COL_OFS;

        if (rsp_vld_reg && rsp_ready)
        begin
            rsp_vld_next = 1'b0;
        end

        // copy write trails its read, landing in the cycle after it
        if (wr_pend_reg)
        begin
            mem_ctl.wr_en = 1'b1;
            mem_ctl.wdata = mem_rd_data;
            mem_waddr     = wr_addr_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    scroll_next  = 1'b0;
                    rd_flag_next = 1'b0;
                    ch_next      = cmd.char_code;
                    unique case (cmd.opcode)
                        OP_PUT:
                        begin
                            if (cmd.char_code == NEWLINE_CODE || col_reg >= COL_FULL)
                            begin
                                col_next = '0;
                                if (row_reg < ROW_LAST)
                                begin
                                    row_next   = row_reg + 1'b1;
                                    state_next = (cmd.char_code == NEWLINE_CODE) ?
                                                 S_FINISH : S_PUTW;
                                end
                                else
                                begin
                                    scroll_next   = 1'b1;
                                    cnt_next      = '0;
                                    wr_pend_next  = 1'b0;
                                    put_pend_next = (cmd.char_code != NEWLINE_CODE);
                                    state_next    = S_COPY;
                                end
                            end
                            else
                            begin
                                mem_ctl.wr_en = 1'b1;
                                mem_ctl.wdata = {attr, cmd.char_code};
                                mem_waddr     = cur_addr;
                                col_next      = col_reg + 1'b1;
                                state_next    = S_FINISH;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            if (rd_in_range)
                            begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = rd_addr;
                                rd_flag_next  = 1'b1;
                            end
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_PUTW:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_ctl.wdata = {attr, ch_reg};
                mem_waddr     = cur_addr;
                col_next      = col_reg + 1'b1;
                state_next    = S_FINISH;
            end
            S_COPY:
            begin
                mem_ctl.rd_en = 1'b1;
                mem_raddr     = cnt_reg + COL_OFS;
                wr_pend_next  = 1'b1;
                wr_addr_next  = cnt_reg;
                if (cnt_reg == COPY_LAST)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                wr_pend_next = 1'b0;
                cnt_next     = LAST_BASE;
                state_next   = S_FILL;
            end
            S_FILL:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = cnt_reg;
                if (cnt_reg == CELL_LAST)
                begin
                    state_next = put_pend_reg ? S_PUTW : S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
                mem_waddr     = cnt_reg;
                if (cnt_reg == CELL_LAST)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FINISH:
            begin
                if (!rsp_vld_reg || rsp_ready)
                begin
                    rsp_vld_next            = 1'b1;
                    rsp_next.cell_char      = rd_flag_reg ? mem_rd_data[7:0]  : 8'd0;
                    rsp_next.cell_attr      = rd_flag_reg ? mem_rd_data[15:8] : 8'd0;
                    rsp_next.cursor_row_out = 5'(row_reg);
                    rsp_next.cursor_col_out = 7'(col_reg);
                    rsp_next.scrolled       = scroll_reg;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            wr_pend_reg  <= 1'b0;
            put_pend_reg <= 1'b0;
            rd_flag_reg  <= 1'b0;
            scroll_reg   <= 1'b0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            wr_pend_reg  <= wr_pend_next;
            put_pend_reg <= put_pend_next;
            rd_flag_reg  <= rd_flag_next;
            scroll_reg   <= scroll_next;
            rsp_vld_reg  <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        wr_addr_reg <= wr_addr_next;
        ch_reg      <= ch_next;
        rsp_reg     <= rsp_next;
    end

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for text_console_writer_core: cursor, wrap, scroll, clear, read
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLS = DEF_COLUMNS;
    localparam int ROWS = DEF_ROWS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic [PADDR_W-1:0] ATTR_ADDR = {REG_ATTR, 2'b00};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    tcw_cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    tcw_rsp_t rsp;

    // console state as the testbench sees it
    logic [7:0] cell_chr [ROWS][COLS];
    logic [7:0] cell_atr [ROWS][COLS];
    bit cell_known [ROWS][COLS];
    int cur_row = 0;
    int cur_col = 0;
    logic [7:0] attr_reg = ATTR_RESET;

    tcw_rsp_t pending_rsp [$];
    tcw_rsp_t oldest_rsp;
    int errors = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    text_console_writer_core #(
        .COLUMNS(COLS),
        .ROWS(ROWS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void write_cell(input int row, input int col, input logic [7:0] chr);
        cell_chr[row][col] = chr;
        cell_atr[row][col] = attr_reg;
        cell_known[row][col] = 1'b1;
    endfunction

    function automatic bit advance_line();
        cur_col = 0;
        if (cur_row < ROWS - 1)
        begin
            cur_row++;
            return 1'b0;
        end
        for (int r = 0; r < ROWS - 1; r++)
        begin
            for (int c = 0; c < COLS; c++)
            begin
                cell_chr[r][c] = cell_chr[r + 1][c];
                cell_atr[r][c] = cell_atr[r + 1][c];
                cell_known[r][c] = cell_known[r + 1][c];
            end
        end
        for (int c = 0; c < COLS; c++)
            write_cell(ROWS - 1, c, SPACE_CODE);
        return 1'b1;
    endfunction

    function automatic tcw_rsp_t console_step(input tcw_cmd_t c);
        tcw_rsp_t r;
        r = '0;
        case (c.opcode)
            OP_PUT:
            begin
                if (c.char_code == NEWLINE_CODE)
                    r.scrolled = advance_line();
                else
                begin
                    if (cur_col >= COLS)
                        r.scrolled = advance_line();
                    write_cell(cur_row, cur_col, c.char_code);
                    cur_col++;
                end
            end
            OP_CLEAR:
            begin
                for (int row = 0; row < ROWS; row++)
                    for (int col = 0; col < COLS; col++)
                        write_cell(row, col, SPACE_CODE);
            end
            OP_READ:
            begin
                if (c.read_row < ROWS && c.read_col < COLS)
                begin
                    r.cell_char = cell_chr[c.read_row][c.read_col];
                    r.cell_attr = cell_atr[c.read_row][c.read_col];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_row_out = 5'(cur_row);
        r.cursor_col_out = 7'(cur_col);
        return r;
    endfunction

    function automatic tcw_cmd_t make_cmd(input logic [1:0] op, input logic [7:0] chr,
                                          input logic [4:0] row, input logic [6:0] col);
        tcw_cmd_t c;
        c.opcode = op;
        c.char_code = chr;
        c.read_row = row;
        c.read_col = col;
        return c;
    endfunction

    function automatic logic [7:0] printable_char();
        logic [7:0] chr;
        do
            chr = 8'($urandom);
        while (chr == NEWLINE_CODE);
        return chr;
    endfunction

    function automatic tcw_cmd_t rand_cmd();
        tcw_cmd_t c;
        int pick;
        pick = $urandom_range(99);
        c = make_cmd(OP_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
        if (pick < 6)
            c.char_code = NEWLINE_CODE;
        else if (pick < 33)
        begin
            c.opcode = OP_READ;
            if (pick < 29)
            begin
                c.read_row = 5'($urandom_range(ROWS - 1));
                c.read_col = 7'($urandom_range(COLS - 1));
            end
            // never read a cell that has not been written since reset
            if (c.read_row < ROWS && c.read_col < COLS && !cell_known[c.read_row][c.read_col])
                c.read_row = 5'(ROWS);
        end
        else if (pick < 35)
            c.opcode = OP_CLEAR;
        else if (pick < 37)
            c.opcode = OP_NONE;
        return c;
    endfunction

    task automatic send_cmd(input tcw_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        pending_rsp.push_back(console_step(c));
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    task automatic put_char(input logic [7:0] chr);
        send_cmd(make_cmd(OP_PUT, chr, 5'($urandom), 7'($urandom)));
    endtask

    task automatic read_cell(input int row, input int col);
        send_cmd(make_cmd(OP_READ, 8'($urandom), 5'(row), 7'(col)));
    endtask

    task automatic wait_drain();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    task automatic check_attribute(input logic [7:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ATTR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[7:0] !== want)
        begin
            $error("attribute: expected %0d, got %0d", want, prdata[7:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_attribute(input logic [7:0] value);
        wait_drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ATTR_ADDR;
        pwdata <= {24'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        attr_reg = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        check_attribute(value);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result item with no command outstanding");
                errors++;
            end
            else
            begin
                oldest_rsp = pending_rsp.pop_front();
                check_field("cell_char", oldest_rsp.cell_char, rsp.cell_char);
                check_field("cell_attr", oldest_rsp.cell_attr, rsp.cell_attr);
                check_field("cursor_row_out", 8'(oldest_rsp.cursor_row_out), 8'(rsp.cursor_row_out));
                check_field("cursor_col_out", 8'(oldest_rsp.cursor_col_out), 8'(rsp.cursor_col_out));
                check_field("scrolled", 8'(oldest_rsp.scrolled), 8'(rsp.scrolled));
            end
        end
        rsp_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("text_console_writer_core regression: fail");
            $finish;
        end
    end

    task automatic test_directed();
        check_attribute(ATTR_RESET);
        put_char(8'h00);
        put_char(8'hFF);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(31, 127);
        send_cmd(make_cmd(OP_NONE, 8'hFF, 5'h1F, 7'h7F));
        send_cmd(make_cmd(OP_CLEAR, 8'hFF, 5'h1F, 7'h7F));
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(ROWS - 1, COLS);
        read_cell(ROWS, 0);
        read_cell(0, 127);
        put_char(NEWLINE_CODE);
        put_char(8'h41);
        read_cell(1, 0);
        send_cmd(make_cmd(OP_READ, 8'h00, 5'h00, 7'h00));
    endtask

    task automatic test_row_wrap();
        set_attribute(8'hFF);
        put_char(NEWLINE_CODE);
        repeat (COLS)
            put_char(printable_char());
        put_char(printable_char());
        read_cell(cur_row, 0);
        read_cell(cur_row - 1, COLS - 1);
        read_cell(cur_row - 1, 0);
    endtask

    task automatic test_bottom_scroll();
        set_attribute(8'($urandom_range(1, 254)));
        while (cur_row < ROWS - 1)
            put_char(NEWLINE_CODE);
        repeat (5)
            put_char(printable_char());
        set_attribute(8'h00);
        put_char(NEWLINE_CODE);
        read_cell(ROWS - 2, 0);
        read_cell(ROWS - 2, 4);
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(0, 0);
        repeat (COLS)
            put_char(printable_char());
        put_char(printable_char());
        read_cell(ROWS - 1, 0);
        read_cell(ROWS - 2, COLS - 1);
    endtask

    task automatic run_random(input int count);
        tcw_cmd_t c;
        int done;
        done = 0;
        while (done < count)
        begin
            c = rand_cmd();
            send_cmd(c);
            if (c.opcode != OP_NONE)
                done++;
        end
    endtask

    task automatic test_random();
        send_idle_pct = 16;
        recv_idle_pct = 47;
        run_random(200);
        set_attribute(8'($urandom));
        send_idle_pct = 47;
        recv_idle_pct = 16;
        run_random(100);
        wait_drain();
        run_random(100);
        set_attribute(8'hFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(100);
        set_attribute(8'h00);
        run_random(100);
    endtask

    initial
    begin
        send_idle_pct = 16;
        recv_idle_pct = 47;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_row_wrap();
        test_bottom_scroll();
        test_random();
        wait_drain();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("text_console_writer_core regression: pass");
        else
            $display("text_console_writer_core regression: fail");
        $finish;
    end
endmodule
